>>> hw/rtl/rgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgt_pkg
// field widths, opcodes and the result beat type of the revision gap tracker
// ----------------------------------------------------------------------------
package rgt_pkg;

  localparam int SRC_W    = 3;
  localparam int REV_W    = 8;
  localparam int LATEST_W = 6;
  localparam int COUNT_W  = 7;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [LATEST_W-1:0] latest_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef struct packed {
    latest_t latest_revision;
    logic    latest_valid;
    count_t  received_count;
    logic    gaps_present;
    logic    was_duplicate;
    logic    out_of_window;
    latest_t missing_revision;
    logic    none_missing;
    logic    last;
  } result_t;

  // gap when the count disagrees with latest plus one
  function automatic logic gap_flag(latest_t latest, logic valid, count_t count);
    return valid && (count != ({1'b0, latest} + count_t'(1)));
  endfunction

endpackage

>>> hw/rtl/revision_gap_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// revision_gap_tracker
// per-source scoreboard of received revision numbers with gap listing
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | op, source_index, revision
//  out      | out_valid / out_ready | latest_revision .. last
//
//  an add passes the accept state and the bitmap read-modify-write state,
//  which waits for a free output register, ending in exactly one out beat
//  a query walks if gaps exist: one shared bit tester walks the snapshot bitmap
//  one position per cycle (a gap waits for a free output), stops at the last gap
//  reset clears every bitmap, latest, valid and count at once; no sweep
//  a full output register stalls every out beat until out_ready frees it
// ----------------------------------------------------------------------------
module revision_gap_tracker #(
  parameter int NUM_SOURCES     = 8,
  parameter int REVISION_WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [rgt_pkg::SRC_W-1:0]     in_source_index,
  input  logic [rgt_pkg::REV_W-1:0]     in_revision,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgt_pkg::LATEST_W-1:0]  out_latest_revision,
  output logic                          out_latest_valid,
  output logic [rgt_pkg::COUNT_W-1:0]   out_received_count,
  output logic                          out_gaps_present,
  output logic                          out_was_duplicate,
  output logic                          out_out_of_window,
  output logic [rgt_pkg::LATEST_W-1:0]  out_missing_revision,
  output logic                          out_none_missing,
  output logic                          out_last
);
  import rgt_pkg::*;

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int BIT_W = $clog2(REVISION_WINDOW);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;

  // captured item
  logic             op_r, op_nxt;
  logic [SRC_W-1:0] src_r, src_nxt;
  logic [REV_W-1:0] rev_r, rev_nxt;

  // per-source scoreboard
  logic [REVISION_WINDOW-1:0] map_r [NUM_SOURCES];
  latest_t                    hi_r  [NUM_SOURCES];
  logic                       any_r [NUM_SOURCES];
  count_t                     cnt_r [NUM_SOURCES];

  // query walk: snapshot shifted right one bit per cycle unless a gap waits
  logic [REVISION_WINDOW-1:0] scan_map_r, scan_map_nxt;
  latest_t                    scan_idx_r, scan_idx_nxt;
  count_t                     remaining_r, remaining_nxt;
  latest_t                    q_latest_r, q_latest_nxt;
  logic                       q_valid_r, q_valid_nxt;
  count_t                     q_count_r, q_count_nxt;

  // output register
  logic    out_valid_r;
  result_t out_r;
  result_t res_c;
  logic    load_out;
  logic    out_free;

  // lookup of the addressed source
  logic                       src_ok;
  logic [IDX_W-1:0]           idx;
  logic [BIT_W-1:0]           bit_sel;
  logic                       in_win;
  logic [REVISION_WINDOW-1:0] cur_map;
  latest_t                    cur_hi;
  logic                       cur_any;
  count_t                     cur_cnt;
  logic                       hit;
  logic                       add_new;
  latest_t                    rev_lat;
  latest_t                    new_hi;
  count_t                     new_cnt;
  count_t                     rem;
  logic                       last_gap;

  assign src_ok   = int'(src_r) < NUM_SOURCES;
  assign idx      = IDX_W'(src_r);
  assign bit_sel  = rev_r[BIT_W-1:0];
  assign in_win   = rev_r < REV_W'(REVISION_WINDOW);
  assign cur_map  = map_r[idx];
  assign cur_hi   = hi_r[idx];
  assign cur_any  = any_r[idx];
  assign cur_cnt  = cnt_r[idx];
  assign hit      = cur_map[bit_sel];
  assign add_new  = (state_r == S_EXEC) && (op_r == OP_ADD) && src_ok && in_win && !hit
                    && out_free;
  assign rev_lat  = rev_r[LATEST_W-1:0];
  assign new_hi   = (!cur_any || (rev_lat > cur_hi)) ? rev_lat : cur_hi;
  assign new_cnt  = cur_cnt + count_t'(1);
  // every received revision lies at or below latest, so this is the gap count
  assign rem      = {1'b0, cur_hi} + count_t'(1) - cur_cnt;
  assign last_gap = remaining_r == count_t'(1);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    src_nxt       = src_r;
    rev_nxt       = rev_r;
    scan_map_nxt  = scan_map_r;
    scan_idx_nxt  = scan_idx_r;
    remaining_nxt = remaining_r;
    q_latest_nxt  = q_latest_r;
    q_valid_nxt   = q_valid_r;
    q_count_nxt   = q_count_r;
    load_out      = 1'b0;
    res_c         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          src_nxt   = in_source_index;
          rev_nxt   = in_revision;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          if (!src_ok) begin
            // unknown source: status stays zero but for the out-of-window or none flag
            res_c.out_of_window = op_r == OP_ADD;
            res_c.none_missing  = op_r == OP_QUERY;
            res_c.last          = 1'b1;
            load_out            = 1'b1;
            state_nxt           = S_IDLE;
          end else if (op_r == OP_ADD) begin
            res_c.latest_revision = add_new ? new_hi : cur_hi;
            res_c.latest_valid    = cur_any || add_new;
            res_c.received_count  = add_new ? new_cnt : cur_cnt;
            res_c.gaps_present    = gap_flag(res_c.latest_revision, res_c.latest_valid,
                                             res_c.received_count);
            res_c.was_duplicate   = in_win && hit;
            res_c.out_of_window   = !in_win;
            res_c.last            = 1'b1;
            load_out              = 1'b1;
            state_nxt             = S_IDLE;
          end else if (!cur_any || (rem == count_t'(0))) begin
            // nothing missing below latest
            res_c.latest_revision = cur_hi;
            res_c.latest_valid    = cur_any;
            res_c.received_count  = cur_cnt;
            res_c.gaps_present    = gap_flag(cur_hi, cur_any, cur_cnt);
            res_c.none_missing    = 1'b1;
            res_c.last            = 1'b1;
            load_out              = 1'b1;
            state_nxt             = S_IDLE;
          end else begin
            scan_map_nxt  = cur_map;
            scan_idx_nxt  = '0;
            remaining_nxt = rem;
            q_latest_nxt  = cur_hi;
            q_valid_nxt   = cur_any;
            q_count_nxt   = cur_cnt;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_map_r[0]) begin
          // received, step on
          scan_map_nxt = scan_map_r >> 1;
          scan_idx_nxt = scan_idx_r + latest_t'(1);
        end else if (out_free) begin
          res_c.latest_revision  = q_latest_r;
          res_c.latest_valid     = q_valid_r;
          res_c.received_count   = q_count_r;
          res_c.gaps_present     = gap_flag(q_latest_r, q_valid_r, q_count_r);
          res_c.missing_revision = scan_idx_r;
          res_c.last             = last_gap;
          load_out               = 1'b1;
          scan_map_nxt           = scan_map_r >> 1;
          scan_idx_nxt           = scan_idx_r + latest_t'(1);
          remaining_nxt          = remaining_r - count_t'(1);
          if (last_gap) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scoreboard, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        map_r[s] <= '0;
        hi_r[s]  <= '0;
        any_r[s] <= 1'b0;
        cnt_r[s] <= '0;
      end
    end else if (add_new) begin
      map_r[idx][bit_sel] <= 1'b1;
      hi_r[idx]           <= new_hi;
      any_r[idx]          <= 1'b1;
      cnt_r[idx]          <= new_cnt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    src_r       <= src_nxt;
    rev_r       <= rev_nxt;
    scan_map_r  <= scan_map_nxt;
    scan_idx_r  <= scan_idx_nxt;
    remaining_r <= remaining_nxt;
    q_latest_r  <= q_latest_nxt;
    q_valid_r   <= q_valid_nxt;
    q_count_r   <= q_count_nxt;
    if (load_out) begin
      out_r <= res_c;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_latest_revision  = out_r.latest_revision;
  assign out_latest_valid     = out_r.latest_valid;
  assign out_received_count   = out_r.received_count;
  assign out_gaps_present     = out_r.gaps_present;
  assign out_was_duplicate    = out_r.was_duplicate;
  assign out_out_of_window    = out_r.out_of_window;
  assign out_missing_revision = out_r.missing_revision;
  assign out_none_missing     = out_r.none_missing;
  assign out_last             = out_r.last;

  // a walk always has a gap still ahead of it, below latest
  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> remaining_r != count_t'(0) && scan_idx_r < q_latest_r)
    else $error("gap walk ran past its last gap");

  // a none-missing beat is always the final beat of its item
  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_missing |-> out_last)
    else $error("none_missing beat without last");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // an add beat never reports a duplicate and a window drop together
  a_add_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_duplicate && out_out_of_window))
    else $error("duplicate and out-of-window both set");

endmodule
